// ===== hdl/lmhq_pkg.sv =====
// Package for the lexicographic max-heap queue unit.
// Holds the heap geometry, the entry type, status codes and the ordering function.
package lmhq_pkg;

  localparam int HeapDepth = 1024;
  localparam int AddrW     = $clog2(HeapDepth);
  localparam int CountW    = $clog2(HeapDepth + 1);
  localparam int EntryW    = 32 + 32 + 16;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  typedef struct packed {
    logic [31:0] cost;
    logic [31:0] capacity;
    logic [15:0] node_id;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;     // capture the request and the count
    logic rd_parent;   // read parent of pos
    logic rd_root;     // read root
    logic rd_last;     // read last entry
    logic rd_left;     // read left child of pos
    logic rd_right;    // read right child of pos
    logic cap_top;     // keep the root as popped entry
    logic cap_last;    // keep read data as moving entry
    logic cap_left;    // keep read data as left child
    logic cap_right;   // keep read data as right child
    logic wr_parent;   // write parent to pos, pos moves up
    logic wr_child;    // write chosen child to pos, pos moves down
    logic wr_final;    // write moving entry at pos
    logic done;        // present result
  } cmd_t;

  typedef struct packed {
    logic       op;
    logic       empty;
    logic       full;
    logic       at_root;
    logic       parent_above; // parent ranks above moving entry
    logic       left_ok;      // left child exists
    logic       right_ok;     // right child exists
    logic       go_down;      // a child ranks above moving entry
  } stat_t;

  // Entry a ranks strictly above b; equal ids never rank above each other.
  function automatic logic ranks_above(entry_t a, entry_t b);
    if (a.node_id == b.node_id) return 1'b0;
    if (a.cost != b.cost) return a.cost > b.cost;
    if (a.capacity != b.capacity) return a.capacity > b.capacity;
    return a.node_id > b.node_id;
  endfunction

endpackage

// ===== hdl/lmhq_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module lmhq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== hdl/lmhq_datapath.sv =====
// Datapath of the heap queue: entry memory, position, count and compare logic.
// Depends on lmhq_pkg and lmhq_ram.
module lmhq_datapath
  import lmhq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  input  logic             in_op,
  input  entry_t           in_entry,
  output stat_t            stat,
  output logic [1:0]       status,
  output entry_t           out_entry,
  output logic [CountW-1:0] fill_count
);
  logic [CountW-1:0] count;
  logic [CountW-1:0] n;
  logic [AddrW-1:0]  pos;
  logic              op;
  entry_t            moving, top, left_e, right_e;
  logic              down_right;
  logic              go_down;
  logic              is_full, is_empty;
  logic [AddrW:0]    left_i, right_i;
  logic [AddrW-1:0]  parent_a;
  logic              we;
  logic [AddrW-1:0]  addr;
  entry_t            wdata, rdata;

  assign left_i   = {pos, 1'b1};
  assign right_i  = {pos, 1'b0} + (AddrW+1)'(2);
  assign parent_a = AddrW'((pos - AddrW'(1)) >> 1);

  assign is_full  = (count == CountW'(HeapDepth));
  assign is_empty = (count == '0);

  // The count moves on as the request is taken, so the controller sees the
  // refusal through the captured status instead.
  assign stat.op           = op;
  assign stat.empty        = (status == STATUS_EMPTY);
  assign stat.full         = (status == STATUS_FULL);
  assign stat.at_root      = (pos == '0);
  assign stat.parent_above = ranks_above(rdata, moving);
  assign stat.left_ok      = (CountW'(left_i) < n) && (left_i <= (AddrW+1)'(HeapDepth - 1));
  assign stat.right_ok     = (CountW'(right_i) < n) && (right_i <= (AddrW+1)'(HeapDepth - 1));
  assign stat.go_down      = go_down;

  // Child selection following the heap rule; left wins ties.
  always_comb begin
    down_right = 1'b0;
    go_down    = 1'b0;
    if (stat.left_ok && ranks_above(left_e, moving)) begin
      go_down    = 1'b1;
      down_right = stat.right_ok && ranks_above(right_e, left_e);
    end else if (stat.right_ok && ranks_above(right_e, moving)) begin
      go_down    = 1'b1;
      down_right = 1'b1;
    end
  end

  always_comb begin
    we    = 1'b0;
    addr  = pos;
    wdata = moving;
    if (cmd.rd_parent) addr = parent_a;
    if (cmd.rd_root)   addr = '0;
    if (cmd.rd_last)   addr = AddrW'(n);
    if (cmd.rd_left)   addr = AddrW'(left_i);
    if (cmd.rd_right)  addr = AddrW'(right_i);
    if (cmd.wr_parent) begin
      we = 1'b1; wdata = rdata;
    end
    if (cmd.wr_child) begin
      we = 1'b1; wdata = down_right ? right_e : left_e;
    end
    if (cmd.wr_final) we = 1'b1;
  end

  lmhq_ram #(.Width(EntryW), .Depth(HeapDepth)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      if (cmd.load_in && in_op == OP_INSERT && !is_full) count <= count + CountW'(1);
      if (cmd.load_in && in_op == OP_POP && !is_empty)   count <= count - CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op     <= in_op;
      moving <= in_entry;
      top    <= '0;
      pos    <= (in_op == OP_INSERT) ? AddrW'(count) : '0;
      n      <= (in_op == OP_INSERT) ? count : count - CountW'(1);
      status <= (in_op == OP_INSERT) ? (is_full ? STATUS_FULL : STATUS_OK)
                                     : (is_empty ? STATUS_EMPTY : STATUS_OK);
    end
    if (cmd.cap_top)   top     <= rdata;
    if (cmd.cap_last)  moving  <= rdata;
    if (cmd.cap_left)  left_e  <= rdata;
    if (cmd.cap_right) right_e <= rdata;
    if (cmd.wr_parent) pos <= parent_a;
    if (cmd.wr_child)  pos <= down_right ? AddrW'(right_i) : AddrW'(left_i);
  end

  assign out_entry  = top;
  assign fill_count = count;
endmodule

// ===== hdl/lmhq_ctrl.sv =====
// Controller state machine of the heap queue.
// Depends on lmhq_pkg.
module lmhq_ctrl
  import lmhq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  strobe
);
  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_DECIDE = 10'b0000000010,
    S_UPRD   = 10'b0000000100,
    S_UPCMP  = 10'b0000001000,
    S_RROOT  = 10'b0000010000,
    S_RLAST  = 10'b0000100000,
    S_RLEFT  = 10'b0001000000,
    S_RRIGHT = 10'b0010000000,
    S_DNCMP  = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_in = 1'b1; state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.op == OP_INSERT) begin
          if (stat.full) state_next = S_DONE;
          else if (stat.at_root) begin
            cmd.wr_final = 1'b1; state_next = S_DONE;
          end else begin
            cmd.rd_parent = 1'b1; state_next = S_UPCMP;
          end
        end else begin
          if (stat.empty) state_next = S_DONE;
          else begin
            cmd.rd_root = 1'b1; state_next = S_RROOT;
          end
        end
      end
      S_UPRD: begin
        if (stat.at_root) begin
          cmd.wr_final = 1'b1; state_next = S_DONE;
        end else begin
          cmd.rd_parent = 1'b1; state_next = S_UPCMP;
        end
      end
      S_UPCMP: begin
        if (stat.parent_above) begin
          cmd.wr_final = 1'b1; state_next = S_DONE;
        end else begin
          cmd.wr_parent = 1'b1; state_next = S_UPRD;
        end
      end
      S_RROOT: begin
        cmd.cap_top = 1'b1; cmd.rd_last = 1'b1; state_next = S_RLAST;
      end
      S_RLAST: begin
        cmd.cap_last = 1'b1; cmd.rd_left = 1'b1; state_next = S_RLEFT;
      end
      S_RLEFT: begin
        cmd.cap_left = 1'b1; cmd.rd_right = 1'b1; state_next = S_RRIGHT;
      end
      S_RRIGHT: begin
        cmd.cap_right = 1'b1; state_next = S_DNCMP;
      end
      S_DNCMP: begin
        if (stat.go_down) begin
          cmd.wr_child = 1'b1; state_next = S_RLAST;
        end else begin
          cmd.wr_final = 1'b1; state_next = S_DONE;
        end
      end
      S_DONE: begin
        cmd.done = 1'b1; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy   = (state != S_IDLE);
  assign strobe = cmd.done;
endmodule

// ===== hdl/lmhq_ctrl_fix.sv =====
// Sequencer wrapper that masks the moving-entry capture after a move down.
// Depends on lmhq_pkg and lmhq_ctrl.
module lmhq_ctrl_fix
  import lmhq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  strobe
);
  cmd_t raw;
  logic after_move;

  lmhq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .stat(stat), .cmd(raw), .strobe(strobe)
  );

  always_ff @(posedge clk) begin
    if (rst) after_move <= 1'b0;
    else     after_move <= raw.wr_child;
  end

  always_comb begin
    cmd = raw;
    if (after_move) cmd.cap_last = 1'b0;
  end
endmodule

// ===== hdl/lexicographic_max_heap_queue_unit.sv =====
// Top level of the lexicographic max-heap queue.
// Requests arrive on start with op, cost, capacity and node_id; accepted when busy is low.
// A request is accepted at a rising edge with start high and busy low. Exactly one
// result follows per request, on status, out_cost, out_capacity, out_node_id and
// fill_count, valid for the single cycle in which done is high; the receiver
// cannot stall it. A full or empty refusal ends without any RAM access. An insert
// climbs one level per parent read and compare, and ends with a write where it
// stops. A pop reads the root and the last entry, then descends one level per
// read of both children and compare, in a heap of up to 1024 entries. The
// single-port entry RAM takes one access a cycle. One request is handled at a time.
// Reset clears the entry count and the controller; the entry RAM needs no clearing
// since entries at or above the count never affect a result.
// Depends on lmhq_pkg, lmhq_ctrl_fix and lmhq_datapath.
module lexicographic_max_heap_queue_unit
  import lmhq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [31:0] cost,
  input  logic [31:0] capacity,
  input  logic [15:0] node_id,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] out_cost,
  output logic [31:0] out_capacity,
  output logic [15:0] out_node_id,
  output logic [10:0] fill_count
);
  cmd_t   cmd;
  stat_t  stat;
  entry_t in_e, out_e;
  logic [CountW-1:0] cnt;

  assign in_e = '{cost: cost, capacity: capacity, node_id: node_id};

  lmhq_ctrl_fix u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .stat(stat), .cmd(cmd), .strobe(done)
  );

  lmhq_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_op(op), .in_entry(in_e),
    .stat(stat), .status(status), .out_entry(out_e), .fill_count(cnt)
  );

  assign out_cost     = out_e.cost;
  assign out_capacity = out_e.capacity;
  assign out_node_id  = out_e.node_id;
  assign fill_count   = 11'(cnt);
endmodule

// ===== tb/lexicographic_max_heap_queue_unit_tb.sv =====
// Testbench for the lexicographic max-heap queue unit: directed, fill-to-full and random phases.
// Keeps its own heap model and checks every result; depends on lmhq_pkg and the unit itself.
`timescale 1ns / 100ps

module lexicographic_max_heap_queue_unit_tb;
  import lmhq_pkg::*;

  typedef struct {
    logic [1:0]  status;
    entry_t      popped;
    logic [10:0] fill;
  } outcome_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        op;
  logic [31:0] cost;
  logic [31:0] capacity;
  logic [15:0] node_id;
  logic        done;
  logic [1:0]  status;
  logic [31:0] out_cost;
  logic [31:0] out_capacity;
  logic [15:0] out_node_id;
  logic [10:0] fill_count;

  entry_t   heap_model[HeapDepth];
  int       held_count;
  outcome_t expected_outcomes[$];
  int       error_count;
  int       burst_left;
  int       quiet_cycles;

  localparam int WatchdogLimit = 4000;

  lexicographic_max_heap_queue_unit i_dut (
    .clk, .rst, .start, .busy, .op, .cost, .capacity, .node_id,
    .done, .status, .out_cost, .out_capacity, .out_node_id, .fill_count
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Strict ordering; entries sharing an id never outrank one another.
  function automatic bit entry_outranks(entry_t a, entry_t b);
    if (a.node_id == b.node_id) return 1'b0;
    if (a.cost != b.cost) return a.cost > b.cost;
    if (a.capacity != b.capacity) return a.capacity > b.capacity;
    return a.node_id > b.node_id;
  endfunction

  function automatic outcome_t apply_heap_request(logic req_op, entry_t e);
    outcome_t res;
    int       pos;
    int       up;
    int       left;
    int       right;
    int       next;
    entry_t   last;
    res.status = STATUS_OK;
    res.popped = '0;
    if (req_op == OP_INSERT) begin
      if (held_count >= HeapDepth) begin
        res.status = STATUS_FULL;
      end else begin
        pos = held_count;
        held_count++;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (entry_outranks(heap_model[up], e)) break;
          heap_model[pos] = heap_model[up];
          pos = up;
        end
        heap_model[pos] = e;
      end
    end else if (held_count == 0) begin
      res.status = STATUS_EMPTY;
    end else begin
      res.popped = heap_model[0];
      last = heap_model[held_count - 1];
      held_count--;
      pos = 0;
      forever begin
        left = 2 * pos + 1;
        right = 2 * pos + 2;
        if (left < held_count && entry_outranks(heap_model[left], last)) begin
          if (right < held_count && entry_outranks(heap_model[right], heap_model[left]))
            next = right;
          else
            next = left;
        end else if (right < held_count && entry_outranks(heap_model[right], last)) begin
          next = right;
        end else begin
          heap_model[pos] = last;
          break;
        end
        heap_model[pos] = heap_model[next];
        pos = next;
      end
    end
    res.fill = held_count[10:0];
    return res;
  endfunction

  // Drives one request, waits for it to be taken and records what should come back.
  task automatic send_request(logic req_op, logic [31:0] c, logic [31:0] cap, logic [15:0] id);
    entry_t e;
    e.cost = c;
    e.capacity = cap;
    e.node_id = id;
    start <= 1'b1;
    op <= req_op;
    cost <= c;
    capacity <= cap;
    node_id <= id;
    do @(posedge clk); while (busy);
    expected_outcomes.push_back(apply_heap_request(req_op, e));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(1, 12);
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
  endtask

  // Keys drawn from a narrow set now and then, so that ties on cost and capacity occur.
  task automatic send_random(int pop_percent);
    logic [31:0] c;
    logic [31:0] cap;
    logic [15:0] id;
    c = $urandom_range(0, 2) == 0 ? 32'($urandom_range(0, 3)) : $urandom;
    cap = $urandom_range(0, 2) == 0 ? 32'($urandom_range(0, 3)) : $urandom;
    id = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 15)) : 16'($urandom);
    send_request($urandom_range(0, 99) < pop_percent ? OP_POP : OP_INSERT, c, cap, id);
  endtask

  task automatic test_directed();
    send_request(OP_POP, 32'd0, 32'd0, 16'd0);
    send_request(OP_INSERT, 32'd0, 32'd0, 16'd0);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'd0, 16'd1);
    send_request(OP_INSERT, 32'h0001_8000, 32'd5, 16'd7);
    // Same keys as the last one, different id: the id breaks the tie.
    send_request(OP_INSERT, 32'h0001_8000, 32'd5, 16'd8);
    // A repeated id, with a larger capacity than its twin.
    send_request(OP_INSERT, 32'h0001_8000, 32'd9, 16'd7);
    send_request(OP_INSERT, 32'd0, 32'hFFFF_FFFF, 16'd2);
    send_request(OP_INSERT, 32'h0001_8000, 32'd5, 16'd9);
    send_request(OP_INSERT, 32'h0001_8000, 32'd5, 16'd9);
    repeat (12) send_request(OP_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    wait_drained();
  endtask

  task automatic test_fill_to_full();
    while (held_count < HeapDepth) send_random(0);
    repeat (4) send_random(0);
    wait_drained();
  endtask

  task automatic test_random_mix();
    repeat (820) send_random(62);
    wait_drained();
  endtask

  always @(posedge clk) begin
    outcome_t exp_out;
    if (!rst && done) begin
      if (expected_outcomes.size() == 0) begin
        $display("%0t: result with no request pending: status %0d", $time, status);
        error_count++;
      end else begin
        exp_out = expected_outcomes.pop_front();
        if (status !== exp_out.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_out.status, status);
          error_count++;
        end
        if (out_cost !== exp_out.popped.cost) begin
          $display("%0t: out_cost expected %h actual %h", $time, exp_out.popped.cost, out_cost);
          error_count++;
        end
        if (out_capacity !== exp_out.popped.capacity) begin
          $display("%0t: out_capacity expected %h actual %h", $time,
                   exp_out.popped.capacity, out_capacity);
          error_count++;
        end
        if (out_node_id !== exp_out.popped.node_id) begin
          $display("%0t: out_node_id expected %h actual %h", $time,
                   exp_out.popped.node_id, out_node_id);
          error_count++;
        end
        if (fill_count !== exp_out.fill) begin
          $display("%0t: fill_count expected %0d actual %0d", $time, exp_out.fill, fill_count);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    op <= OP_INSERT;
    cost <= '0;
    capacity <= '0;
    node_id <= '0;
    error_count = 0;
    held_count = 0;
    burst_left = 0;
    quiet_cycles = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_fill_to_full();
    test_random_mix();
    repeat (60) @(posedge clk);
    if (error_count == 0 && expected_outcomes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
